// ===== sv/cq_pkg.sv =====
// Shared constants, codes and helpers for the circular queue block.
`default_nettype none

package cq_pkg;

  // Queue geometry
  localparam int CAPACITY   = 8;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  // One bit wider than the count, for index-plus-offset compares
  typedef logic [CNT_W:0]   cmp_t;

  // Operation codes; code seven is a no-op
  typedef enum logic [2:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_FRONT  = 3'd2,
    OP_BACK   = 3'd3,
    OP_SEARCH = 3'd4,
    OP_REMV   = 3'd5,
    OP_REMI   = 3'd6
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e;

  // Ring slot of base plus offset, wrapping at the capacity
  function automatic ptr_t slot_add(input ptr_t base, input ptr_t offs);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (PTR_W+1)'(CAPACITY)) begin
      sum = sum - (PTR_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Ring slot one before base
  function automatic ptr_t slot_dec(input ptr_t base);
    ptr_t res;
    if (base == '0) begin
      res = PTR_W'(CAPACITY - 1);
    end else begin
      res = base - PTR_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/circular_queue_with_search_remove.sv =====
// Top level: circular FIFO with search and removal, driven by a small sequencer.
`default_nettype none

// Circular FIFO of eight signed 32-bit words. A request is taken when start_i
// is high and busy_o low; its one result appears for exactly one cycle with
// done_o high and must be captured then, as there is no way to stall it. The
// entries live in a one-write, one-read RAM with registered read data, and all
// walking over entries goes through that single read port, one entry a cycle.
// Enqueue, the no-op code and any request answered at the first check (dequeue
// or peek on an empty queue, search or removal by value on an empty queue, bad
// index) end there; otherwise dequeue and the peeks wait for one RAM read, a
// search walks entries from the head until a match or the last one, removal by
// value then moves each entry behind the match one slot toward the head, and
// removal by index does so for the entries behind the index. The longest
// request is a removal by value over a full queue. A new request may be started
// in the cycle the result is shown. Occupancy is reported after the operation.
module circular_queue_with_search_remove (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [2:0]                        op_i,
  input  wire logic signed [cq_pkg::DATA_WIDTH-1:0] value_i,
  input  wire logic [cq_pkg::PTR_W-1:0]          index_i,
  output logic                                   done_o,
  output logic signed [cq_pkg::DATA_WIDTH-1:0]   data_o,
  output logic [cq_pkg::PTR_W-1:0]               position_o,
  output logic [cq_pkg::CNT_W-1:0]               occupancy_o,
  output logic [2:0]                             status_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SCAN,
    S_SH_RD,
    S_SH_MOV
  } state_e;

  state_e                              state_q, state_d;
  cq_pkg::op_e                         op_q, op_d;
  logic [cq_pkg::DATA_WIDTH-1:0]       value_q, value_d;
  cq_pkg::ptr_t                        index_q, index_d;
  cq_pkg::ptr_t                        head_q, head_d;
  cq_pkg::ptr_t                        tail_q, tail_d;
  cq_pkg::cnt_t                        count_q, count_d;
  cq_pkg::ptr_t                        scan_q, scan_d;
  logic                                done_q, done_d;
  logic [cq_pkg::DATA_WIDTH-1:0]       data_q, data_d;
  cq_pkg::ptr_t                        pos_q, pos_d;
  cq_pkg::status_e                     status_q, status_d;

  logic                                ram_we;
  cq_pkg::ptr_t                        ram_waddr;
  logic [cq_pkg::DATA_WIDTH-1:0]       ram_wdata;
  cq_pkg::ptr_t                        ram_raddr;
  logic [cq_pkg::DATA_WIDTH-1:0]       ram_rdata;

  cq_pkg::cmp_t                        scan_p1;
  cq_pkg::cmp_t                        scan_p2;
  cq_pkg::cmp_t                        count_ext;

  // Entry store
  cq_ram #(
    .WIDTH(cq_pkg::DATA_WIDTH),
    .DEPTH(cq_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Walk index compares against occupancy
  assign scan_p1   = cq_pkg::cmp_t'(scan_q) + cq_pkg::cmp_t'(1);
  assign scan_p2   = cq_pkg::cmp_t'(scan_q) + cq_pkg::cmp_t'(2);
  assign count_ext = cq_pkg::cmp_t'(count_q);

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    value_d   = value_q;
    index_d   = index_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    scan_d    = scan_q;
    done_d    = 1'b0;
    data_d    = data_q;
    pos_d     = pos_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = value_q;
    ram_raddr = head_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = cq_pkg::op_e'(op_i);
          value_d = value_i;
          index_d = index_i;
          data_d  = '0;
          pos_d   = '0;
          state_d = S_EXEC;
        end
      end

      // First step of every operation: checks and, where there is one, the first access
      S_EXEC: begin
        case (op_q)
          cq_pkg::OP_ENQ: begin
            if (count_q == cq_pkg::cnt_t'(cq_pkg::CAPACITY)) begin
              status_d = cq_pkg::ST_FULL;
            end else begin
              tail_d    = cq_pkg::slot_add(tail_q, cq_pkg::ptr_t'(1));
              ram_we    = 1'b1;
              ram_waddr = tail_d;
              count_d   = count_q + cq_pkg::cnt_t'(1);
              status_d  = cq_pkg::ST_OK;
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          cq_pkg::OP_DEQ, cq_pkg::OP_FRONT, cq_pkg::OP_BACK: begin
            if (count_q == '0) begin
              status_d = cq_pkg::ST_EMPTY;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              ram_raddr = (op_q == cq_pkg::OP_BACK) ? tail_q : head_q;
              state_d   = S_RD_WAIT;
            end
          end
          cq_pkg::OP_SEARCH, cq_pkg::OP_REMV: begin
            if (count_q == '0) begin
              status_d = cq_pkg::ST_NOT_FOUND;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              scan_d    = '0;
              ram_raddr = head_q;
              state_d   = S_SCAN;
            end
          end
          cq_pkg::OP_REMI: begin
            if (cq_pkg::cnt_t'(index_q) >= count_q) begin
              status_d = cq_pkg::ST_BAD_INDEX;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              scan_d  = index_q;
              state_d = S_SH_RD;
            end
          end
          default: begin
            status_d = cq_pkg::ST_OK;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end
        endcase
      end

      // Read data for dequeue and peeks
      S_RD_WAIT: begin
        data_d = ram_rdata;
        if (op_q == cq_pkg::OP_DEQ) begin
          head_d  = cq_pkg::slot_add(head_q, cq_pkg::ptr_t'(1));
          count_d = count_q - cq_pkg::cnt_t'(1);
        end
        status_d = cq_pkg::ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      // Compare one entry per cycle, reading the next one meanwhile
      S_SCAN: begin
        if (ram_rdata == value_q) begin
          pos_d = scan_q;
          if (op_q == cq_pkg::OP_SEARCH) begin
            status_d = cq_pkg::ST_OK;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_SH_RD;
          end
        end else if (scan_p1 >= count_ext) begin
          status_d = cq_pkg::ST_NOT_FOUND;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          scan_d    = scan_q + cq_pkg::ptr_t'(1);
          ram_raddr = cq_pkg::slot_add(head_q, scan_d);
        end
      end

      // Start of gap closing: fetch the entry behind the removed one, or finish when there is none
      S_SH_RD: begin
        if (scan_p1 < count_ext) begin
          ram_raddr = cq_pkg::slot_add(head_q, scan_q + cq_pkg::ptr_t'(1));
          state_d   = S_SH_MOV;
        end else begin
          tail_d   = cq_pkg::slot_dec(tail_q);
          count_d  = count_q - cq_pkg::cnt_t'(1);
          status_d = cq_pkg::ST_OK;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // Move one entry toward the head per cycle, prefetching the next
      S_SH_MOV: begin
        ram_we    = 1'b1;
        ram_waddr = cq_pkg::slot_add(head_q, scan_q);
        ram_wdata = ram_rdata;
        scan_d    = scan_q + cq_pkg::ptr_t'(1);
        if (scan_p2 < count_ext) begin
          ram_raddr = cq_pkg::slot_add(head_q, scan_q + cq_pkg::ptr_t'(2));
        end else begin
          tail_d   = cq_pkg::slot_dec(tail_q);
          count_d  = count_q - cq_pkg::cnt_t'(1);
          status_d = cq_pkg::ST_OK;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= cq_pkg::OP_ENQ;
      value_q  <= '0;
      index_q  <= '0;
      head_q   <= '0;
      tail_q   <= cq_pkg::ptr_t'(cq_pkg::CAPACITY - 1);
      count_q  <= '0;
      scan_q   <= '0;
      done_q   <= 1'b0;
      data_q   <= '0;
      pos_q    <= '0;
      status_q <= cq_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      value_q  <= value_d;
      index_q  <= index_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      scan_q   <= scan_d;
      done_q   <= done_d;
      data_q   <= data_d;
      pos_q    <= pos_d;
      status_q <= status_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign data_o      = data_q;
  assign position_o  = pos_q;
  assign occupancy_o = count_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // A result strobe always drops again straight after it is shown
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // Occupancy never exceeds the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cq_pkg::cnt_t'(cq_pkg::CAPACITY))
    else $error("occupancy above capacity");

  // A transfer in makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not start");

  // A refused enqueue is only reported on a full queue
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == cq_pkg::ST_FULL)
      |-> occupancy_o == cq_pkg::cnt_t'(cq_pkg::CAPACITY))
    else $error("full status with free slots");

  // Occupancy only moves in the cycle a result is produced
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_d |=> $stable(count_q))
    else $error("occupancy changed without a result");
`endif

endmodule

`default_nettype wire
